>>> rtl/vasr_pkg.sv
// Shared constants and types for the voice activated segment recorder.
package vasr_pkg;

    // Samples per block unless the source marks an earlier end.
    localparam int BLOCK_LENGTH = 256;
    // Ring size in blocks; a power of two.
    localparam int RING_BLOCKS  = 8192;

    localparam int ENERGY_W   = 40;
    localparam int COUNT_W    = 12;
    localparam int NUM_W      = COUNT_W + 1;
    localparam int DIV_STEP_W = 6;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 17;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    localparam logic [NUM_W-1:0]      BLOCK_LEN_N = NUM_W'(BLOCK_LENGTH);
    localparam logic [15:0]           RING_MASK   = 16'(RING_BLOCKS - 1);
    localparam logic [ENERGY_W-1:0]   ENERGY_MAX  = '1;
    localparam logic [DIV_STEP_W-1:0] DIV_LAST    = DIV_STEP_W'(ENERGY_W - 1);

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ATTACK_THRESHOLD  = 3'd0,
        REG_RELEASE_THRESHOLD = 3'd1,
        REG_SILENCE_BLOCKS    = 3'd2,
        REG_MAX_BLOCKS        = 3'd3,
        REG_SMOOTHING_ALPHA   = 3'd4
    } cfg_index_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV,
        ST_SQRT,
        ST_MUL1,
        ST_MUL2,
        ST_DECIDE
    } vasr_state_t;

endpackage

>>> rtl/vasr_channels.sv
// Valid/ready channel interfaces for samples in and block results out.

interface vasr_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        last_of_block;

    modport source (output valid, output sample, output last_of_block, input ready);
    modport sink   (input valid, input sample, input last_of_block, output ready);
endinterface

interface vasr_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] level;
    logic        recording_now;
    logic        write_valid;
    logic [12:0] write_slot;
    logic        segment_done;
    logic        segment_aborted;
    logic [15:0] segment_start;
    logic [15:0] segment_end;

    modport source (
        output valid, output level, output recording_now, output write_valid,
        output write_slot, output segment_done, output segment_aborted,
        output segment_start, output segment_end, input ready
    );
    modport sink (
        input valid, input level, input recording_now, input write_valid,
        input write_slot, input segment_done, input segment_aborted,
        input segment_start, input segment_end, output ready
    );
endinterface

>>> rtl/voice_activated_segment_recorder_unit.sv
// Voice activated segment recorder: block RMS level, smoothing and segment control.
//
// Each sample transfer is accepted, then squared and added through the shared
// multiplier; no new sample is taken until the block is back in idle. The sample
// that ends a block then passes through an accept, an accumulate, 40 restoring
// division steps of the energy by the sample count, 16 square root steps (both on
// one shared subtractor), the smoothing multiplies MUL1 and MUL2 on the shared
// 32x17 multiplier and a decision state that loads the result register. The
// result register holds one result; a block end waits in the decision state only
// while an earlier result is still not taken. Configuration writes take effect at
// once; the user must see that they are made while the block is idle; the block
// itself does not enforce this.
module voice_activated_segment_recorder_unit
    import vasr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    vasr_sample_if.sink          samples,
    vasr_result_if.source        results,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    // Configuration registers.
    logic [15:0] attack_reg;
    logic [15:0] release_reg;
    logic [11:0] silence_reg;
    logic [11:0] max_reg;
    logic [15:0] alpha_reg;

    // Sequencer.
    vasr_state_t state_reg, state_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;

    // Block state.
    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [31:0]         level_reg, level_next;
    logic                recording_reg, recording_next;
    logic [15:0]         start_reg, start_next;
    logic [15:0]         current_reg, current_next;
    logic [15:0]         silence_pt_reg, silence_pt_next;

    // Working registers.
    logic [16:0]         mag_reg, mag_next;
    logic                last_reg, last_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [ENERGY_W-1:0] dvd_reg, dvd_next;
    logic [NUM_W-1:0]    rem_reg, rem_next;
    logic [31:0]         rad_reg, rad_next;
    logic [31:0]         root_reg, root_next;
    logic [31:0]         bit_reg, bit_next;
    logic [MUL_P_W-1:0]  prod_reg, prod_next;

    // Result register.
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_level_reg, out_level_next;
    logic        out_rec_reg, out_rec_next;
    logic        out_wv_reg, out_wv_next;
    logic [12:0] out_slot_reg, out_slot_next;
    logic        out_done_reg, out_done_next;
    logic        out_abort_reg, out_abort_next;
    logic [15:0] out_start_reg, out_start_next;
    logic [15:0] out_end_reg, out_end_next;

    // Shared units.
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [31:0]        sub_a;
    logic [31:0]        sub_b;
    logic [32:0]        sub_d;
    logic               sub_ge;

    // Derived terms.
    logic [NUM_W-1:0]    num_inc;
    logic                block_end;
    logic [ENERGY_W:0]   energy_sum;
    logic [ENERGY_W-1:0] energy_sat;
    logic                result_free;
    logic signed [16:0]  sample_ext;

    assign mul_p  = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
    assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge = ~sub_d[32];

    assign num_inc     = NUM_W'(count_reg) + NUM_W'(1);
    assign block_end   = last_reg || (num_inc >= BLOCK_LEN_N);
    assign energy_sum  = {1'b0, energy_reg} + (ENERGY_W + 1)'(mul_p);
    assign energy_sat  = energy_sum[ENERGY_W] ? ENERGY_MAX : energy_sum[ENERGY_W-1:0];
    assign result_free = ~out_valid_reg || results.ready;
    assign sample_ext  = 17'(signed'(samples.sample));

    assign samples.ready = (state_reg == ST_IDLE);

    assign results.valid           = out_valid_reg;
    assign results.level           = out_level_reg;
    assign results.recording_now   = out_rec_reg;
    assign results.write_valid     = out_wv_reg;
    assign results.write_slot      = out_slot_reg;
    assign results.segment_done    = out_done_reg;
    assign results.segment_aborted = out_abort_reg;
    assign results.segment_start   = out_start_reg;
    assign results.segment_end     = out_end_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= 16'd1638;
            release_reg <= 16'd328;
            silence_reg <= 12'd170;
            max_reg     <= 12'd1000;
            alpha_reg   <= 16'd4588;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ATTACK_THRESHOLD:  attack_reg  <= cfg_data;
                REG_RELEASE_THRESHOLD: release_reg <= cfg_data;
                REG_SILENCE_BLOCKS:    silence_reg <= cfg_data[11:0];
                REG_MAX_BLOCKS:        max_reg     <= cfg_data[11:0];
                REG_SMOOTHING_ALPHA:   alpha_reg   <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (samples.valid) state_next = ST_ACCUM;
            ST_ACCUM:  state_next = block_end ? ST_DIV : ST_IDLE;
            ST_DIV:    if (step_reg == '0) state_next = ST_SQRT;
            ST_SQRT:   if (bit_reg[0]) state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_DECIDE;
            ST_DECIDE: if (result_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and result updates for each state.
    always_comb
    begin
        logic        rec;
        logic [15:0] cb;
        logic [15:0] sb;
        logic [15:0] sil;
        logic [15:0] slot_full;
        logic [15:0] seg_end;
        logic [49:0] acc;
        logic        wv;
        logic        dn;
        logic        ab;
        logic [15:0] ss;
        logic [15:0] se;
        logic [12:0] ws;

        step_next       = step_reg;
        energy_next     = energy_reg;
        count_next      = count_reg;
        level_next      = level_reg;
        recording_next  = recording_reg;
        start_next      = start_reg;
        current_next    = current_reg;
        silence_pt_next = silence_pt_reg;
        mag_next        = mag_reg;
        last_next       = last_reg;
        num_next        = num_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        rad_next        = rad_reg;
        root_next       = root_reg;
        bit_next        = bit_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        out_level_next  = out_level_reg;
        out_rec_next    = out_rec_reg;
        out_wv_next     = out_wv_reg;
        out_slot_next   = out_slot_reg;
        out_done_next   = out_done_reg;
        out_abort_next  = out_abort_reg;
        out_start_next  = out_start_reg;
        out_end_next    = out_end_reg;
        mul_a           = '0;
        mul_b           = '0;
        sub_a           = '0;
        sub_b           = '0;
        rec             = recording_reg;
        cb              = current_reg;
        sb              = start_reg;
        sil             = silence_pt_reg;
        slot_full       = '0;
        seg_end         = '0;
        acc             = '0;
        wv              = 1'b0;
        dn              = 1'b0;
        ab              = 1'b0;
        ss              = '0;
        se              = '0;
        ws              = '0;

        case (state_reg)
            // Take the sample transfer and keep its magnitude.
            ST_IDLE:
            begin
                if (samples.valid)
                begin
                    mag_next  = sample_ext[16] ? 17'(-sample_ext) : 17'(sample_ext);
                    last_next = samples.last_of_block;
                end
            end

            // Square and add, then either count the sample or start the mean.
            ST_ACCUM:
            begin
                mul_a = MUL_A_W'(mag_reg);
                mul_b = mag_reg;
                if (block_end)
                begin
                    energy_next = '0;
                    count_next  = '0;
                    dvd_next    = energy_sat;
                    rem_next    = '0;
                    num_next    = num_inc;
                    step_next   = DIV_LAST;
                end
                else
                begin
                    energy_next = energy_sat;
                    count_next  = num_inc[COUNT_W-1:0];
                end
            end

            // One quotient bit per cycle of energy over sample count.
            ST_DIV:
            begin
                sub_a = 32'({rem_reg, dvd_reg[ENERGY_W-1]});
                sub_b = 32'(num_reg);
                if (sub_ge)
                    rem_next = sub_d[NUM_W-1:0];
                else
                    rem_next = {rem_reg[NUM_W-2:0], dvd_reg[ENERGY_W-1]};
                dvd_next  = {dvd_reg[ENERGY_W-2:0], sub_ge};
                step_next = step_reg - DIV_STEP_W'(1);
                if (step_reg == '0)
                begin
                    rad_next  = dvd_next[31:0];
                    root_next = '0;
                    bit_next  = 32'h4000_0000;
                end
            end

            // One root bit per cycle.
            ST_SQRT:
            begin
                sub_a = rad_reg;
                sub_b = root_reg + bit_reg;
                if (sub_ge)
                begin
                    rad_next  = sub_d[31:0];
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end

            // Old level times the complement of alpha.
            ST_MUL1:
            begin
                mul_a     = level_reg;
                mul_b     = MUL_B_W'(17'h1_0000 - {1'b0, alpha_reg});
                prod_next = mul_p;
            end

            // New RMS times alpha, add and round half up.
            ST_MUL2:
            begin
                mul_a      = MUL_A_W'(root_reg[15:0]);
                mul_b      = {1'b0, alpha_reg};
                acc        = 50'(prod_reg) + (50'(mul_p) << 16) + 50'(32768);
                level_next = acc[47:16];
            end

            // Segment control and result load.
            ST_DECIDE:
            begin
                if (!rec && (level_reg > {attack_reg, 16'h0000}))
                begin
                    rec = 1'b1;
                    cb  = sb;
                    sil = sb;
                end
                if (rec)
                begin
                    wv        = 1'b1;
                    slot_full = cb & RING_MASK;
                    ws        = slot_full[12:0];
                    cb        = cb + 16'd1;
                    if (level_reg > {release_reg, 16'h0000})
                        sil = cb;
                    if ((cb - sb) > {4'h0, max_reg})
                    begin
                        rec = 1'b0;
                        ab  = 1'b1;
                        cb  = sb;
                        sil = sb;
                    end
                    else if ((cb - sil) > {4'h0, silence_reg})
                    begin
                        rec     = 1'b0;
                        dn      = 1'b1;
                        seg_end = cb - {4'h0, silence_reg};
                        ss      = sb;
                        se      = seg_end;
                        sb      = seg_end;
                        sil     = seg_end;
                        cb      = seg_end;
                    end
                end
                if (result_free)
                begin
                    recording_next  = rec;
                    current_next    = cb;
                    start_next      = sb;
                    silence_pt_next = sil;
                    out_valid_next  = 1'b1;
                    out_level_next  = level_reg[31:16];
                    out_rec_next    = rec;
                    out_wv_next     = wv;
                    out_slot_next   = ws;
                    out_done_next   = dn;
                    out_abort_next  = ab;
                    out_start_next  = ss;
                    out_end_next    = se;
                end
            end

            default: ;
        endcase
    end

    // Control and block state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= '0;
            energy_reg     <= '0;
            count_reg      <= '0;
            level_reg      <= '0;
            recording_reg  <= 1'b0;
            start_reg      <= '0;
            current_reg    <= '0;
            silence_pt_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            energy_reg     <= energy_next;
            count_reg      <= count_next;
            level_reg      <= level_next;
            recording_reg  <= recording_next;
            start_reg      <= start_next;
            current_reg    <= current_next;
            silence_pt_reg <= silence_pt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        last_reg      <= last_next;
        num_reg       <= num_next;
        dvd_reg       <= dvd_next;
        rem_reg       <= rem_next;
        rad_reg       <= rad_next;
        root_reg      <= root_next;
        bit_reg       <= bit_next;
        prod_reg      <= prod_next;
        out_level_reg <= out_level_next;
        out_rec_reg   <= out_rec_next;
        out_wv_reg    <= out_wv_next;
        out_slot_reg  <= out_slot_next;
        out_done_reg  <= out_done_next;
        out_abort_reg <= out_abort_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
    end

endmodule
